// File: hw/rtl/rce_pkg.sv
package rce_pkg;

	localparam int MAX_WIDTH_DEF = 2048;
	localparam int MAX_HEIGHT    = 4096;

	localparam int PIX_W  = 8;
	localparam int ROW_W  = 12;
	localparam int COL_W  = 11;
	localparam int WREG_W = 12;
	localparam int HREG_W = 13;
	localparam int CFG_W  = 13;

	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;

	localparam int OUT_DATA_W = 32;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		STEP_MAIN,
		STEP_RIGHT,
		STEP_BELOW,
		STEP_CORNER
	} step_t;

endpackage

// File: hw/rtl/rce_line_buf.sv
module rce_line_buf #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11,
	parameter int DW    = 8
) (
	input  logic          clk,
	input  logic          en,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			rdata      <= mem[addr];
			mem[addr]  <= wdata;
		end
	end

endmodule

// File: hw/rtl/roberts_cross_edge_filter.sv
// Roberts cross edge filter. Takes 8-bit grayscale pixels in raster order, one per beat, and
// emits the low eight bits of |p(r,c)-p(r+1,c+1)| + |p(r+1,c)-p(r,c+1)| for every pixel of the
// frame, tagged with row and column; the last row and column repeat their neighbor's value and
// the bottom-right corner passes the source pixel through with tlast set. A result for (r,c)
// leaves once pixel (r+1,c+1) is in, so the first row and column of input give no output.
// With the output ready the block takes one pixel per clock except in the last row: there
// every pixel from the second column on yields at least two results, so each pixel from the
// third column on waits in the input stage until the previous pixel's last result is taken.
// The extra results of the last column and of the corner leave while the following pixels,
// which give none, pass through. The first result of a pixel is offered from the result
// register, after the pixel has passed the input stage, which also holds the registered line
// buffer read. Writing either register restarts the frame; write only while no results are
// outstanding. Line buffer contents are not cleared at reset.
module roberts_cross_edge_filter #(
	parameter int MAX_WIDTH = rce_pkg::MAX_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  rce_pkg::reg_idx_t             cfg_index,
	input  logic [rce_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // pixel_in
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [rce_pkg::OUT_DATA_W-1:0] m_axis_tdata, // out_row, out_col, edge_value, pad
	output logic                          m_axis_tlast   // frame_done
);

	import rce_pkg::*;

	localparam int AW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int CW = 14;

	logic [WREG_W-1:0] width_q;
	logic [HREG_W-1:0] height_q;
	logic [CW-1:0]     w_eff, w_last;
	logic [HREG_W-1:0] h_eff;
	logic [ROW_W-1:0]  h_last;

	logic [AW-1:0]     x_q;
	logic [ROW_W-1:0]  y_q;
	logic              last_col, last_row, in_acc;

	logic              valid_s1, lc_s1, lr_s1, has_s1, s1_adv;
	logic [PIX_W-1:0]  pix_s1, up_s1;
	logic [AW-1:0]     x_s1;
	logic [ROW_W-1:0]  y_s1;

	logic [PIX_W-1:0]  ul_q, left_q, d0, d1, grad;

	logic              e_valid_q, e_lc_q, e_lr_q, e_done, emit_free, out_acc;
	logic [PIX_W-1:0]  e_g_q, e_pix_q;
	logic [AW-1:0]     e_x_q;
	logic [ROW_W-1:0]  e_y_q;
	step_t             step_q, step_nxt;

	logic [ROW_W-1:0]  o_row;
	logic [AW-1:0]     o_col;
	logic [PIX_W-1:0]  o_val;
	logic              o_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WREG_W'(RESET_WIDTH);
			height_q <= HREG_W'(RESET_HEIGHT);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[WREG_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[HREG_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		if (CW'(width_q) < CW'(2))
			w_eff = CW'(2);
		else if (CW'(width_q) > CW'(MAX_WIDTH))
			w_eff = CW'(MAX_WIDTH);
		else
			w_eff = CW'(width_q);
		w_last = w_eff - CW'(1);

		if (height_q < HREG_W'(2))
			h_eff = HREG_W'(2);
		else if (height_q > HREG_W'(MAX_HEIGHT))
			h_eff = HREG_W'(MAX_HEIGHT);
		else
			h_eff = height_q;
		h_last = ROW_W'(h_eff - HREG_W'(1));
	end

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign last_col = CW'(x_q) >= w_last;
	assign last_row = y_q >= h_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
		end else if (cfg_we) begin
			x_q <= '0;
			y_q <= '0;
		end else if (in_acc) begin
			if (last_col) begin
				x_q <= '0;
				y_q <= last_row ? '0 : y_q + ROW_W'(1);
			end else begin
				x_q <= x_q + AW'(1);
			end
		end
	end

	rce_line_buf #(
		.DEPTH (MAX_WIDTH),
		.AW    (AW),
		.DW    (PIX_W)
	) u_line_buf (
		.clk   (clk),
		.en    (in_acc),
		.addr  (x_q),
		.wdata (s_axis_tdata),
		.rdata (up_s1)
	);

	assign has_s1        = (x_s1 != '0) && (y_s1 != '0);
	assign out_acc       = e_valid_q && m_axis_tready;
	assign emit_free     = !e_valid_q || (m_axis_tready && e_done);
	assign s1_adv        = valid_s1 && (!has_s1 || emit_free);
	assign s_axis_tready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_acc)
			valid_s1 <= 1'b1;
		else if (s1_adv)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1 <= s_axis_tdata;
			x_s1   <= x_q;
			y_s1   <= y_q;
			lc_s1  <= last_col;
			lr_s1  <= last_row;
		end
	end

	assign d0   = (ul_q > pix_s1) ? ul_q - pix_s1 : pix_s1 - ul_q;
	assign d1   = (left_q > up_s1) ? left_q - up_s1 : up_s1 - left_q;
	assign grad = d0 + d1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ul_q   <= '0;
			left_q <= '0;
		end else if (cfg_we || (s1_adv && lc_s1)) begin
			ul_q   <= '0;
			left_q <= '0;
		end else if (s1_adv) begin
			ul_q   <= up_s1;
			left_q <= pix_s1;
		end
	end

	always_comb begin
		step_nxt = STEP_MAIN;
		e_done   = 1'b1;
		case (step_q)
			STEP_MAIN: begin
				if (e_lc_q) begin
					step_nxt = STEP_RIGHT;
					e_done   = 1'b0;
				end else if (e_lr_q) begin
					step_nxt = STEP_BELOW;
					e_done   = 1'b0;
				end
			end
			STEP_RIGHT: begin
				if (e_lr_q) begin
					step_nxt = STEP_BELOW;
					e_done   = 1'b0;
				end
			end
			STEP_BELOW: begin
				if (e_lc_q) begin
					step_nxt = STEP_CORNER;
					e_done   = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		o_row  = e_y_q - ROW_W'(1);
		o_col  = e_x_q - AW'(1);
		o_val  = e_g_q;
		o_last = 1'b0;
		case (step_q)
			STEP_MAIN: ;
			STEP_RIGHT: o_col = e_x_q;
			STEP_BELOW: o_row = e_y_q;
			STEP_CORNER: begin
				o_row  = e_y_q;
				o_col  = e_x_q;
				o_val  = e_pix_q;
				o_last = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_valid_q <= 1'b0;
			step_q    <= STEP_MAIN;
		end else if (s1_adv && has_s1) begin
			e_valid_q <= 1'b1;
			step_q    <= STEP_MAIN;
		end else if (out_acc) begin
			if (e_done)
				e_valid_q <= 1'b0;
			else
				step_q <= step_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && has_s1) begin
			e_g_q   <= grad;
			e_pix_q <= pix_s1;
			e_x_q   <= x_s1;
			e_y_q   <= y_s1;
			e_lc_q  <= lc_s1;
			e_lr_q  <= lr_s1;
		end
	end

	assign m_axis_tvalid = e_valid_q;
	assign m_axis_tlast  = o_last;
	assign m_axis_tdata  = {1'b0, o_val, COL_W'(o_col), o_row};

endmodule

// File: hw/rtl/rce_checker.sv
module rce_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [rce_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic                           m_axis_tlast
);

	import rce_pkg::*;

	logic             seen_last_q;
	logic [ROW_W-1:0] row;
	logic [COL_W-1:0] col;

	assign row = m_axis_tdata[ROW_W-1:0];
	assign col = m_axis_tdata[ROW_W+COL_W-1:ROW_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seen_last_q <= 1'b0;
		else if (m_axis_tvalid && m_axis_tready)
			seen_last_q <= m_axis_tlast;
	end

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result beat dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result beat changed while stalled");

	a_corner_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> row != '0 && col != '0)
		else $error("frame end marked at first row or column");

	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && seen_last_q |-> row == '0 && col == '0)
		else $error("new frame does not start at the origin");

endmodule

bind roberts_cross_edge_filter rce_checker u_rce_checker (.*);
